### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers; clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/csmc_pkg.sv
// ----------------------------------------------------------------------------
// csmc_pkg
// Types and constants of the clock set-mode controller.
// ----------------------------------------------------------------------------
package csmc_pkg;

  localparam int unsigned SecsPerDay     = 86400;
  localparam int unsigned SecsPerHour    = 3600;
  localparam int unsigned SecsPerMin     = 60;
  localparam int unsigned HoursPerDay    = 24;
  localparam int unsigned MinsPerHour    = 60;
  localparam int unsigned FineMax        = 99;
  localparam int unsigned TimeoutDefault = 60 * 125;

  // minute = (rem / 4) / 15, via reciprocal: exact for rem / 4 < 900
  localparam int unsigned MinRecip = 1093;
  localparam int unsigned MinShift = 14;

  typedef enum logic [1:0] {
    CmdTick = 2'd0,
    CmdNext = 2'd1,
    CmdInc  = 2'd2,
    CmdNone = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ModeTime   = 2'd0,
    ModeHour   = 2'd1,
    ModeMinute = 2'd2,
    ModeFine   = 2'd3
  } mode_e;

  // time of day broken into hour and minute
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } split_t;

endpackage

### sv/clock_set_mode_controller_top.sv
// ----------------------------------------------------------------------------
// clock_set_mode_controller_top
// A request is captured in the input register on accept; the state update is then
// registered into the result register (input register, then result register).
// Throughput: one event per cycle; each stage advances when the next one drains.
// Reset: time display, 12-hour format, edit values and countdown at 0,
// timeout_frames at 7500; pipeline empty.
// ----------------------------------------------------------------------------
module clock_set_mode_controller_top
  import csmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_wen_i,
  input  logic [15:0] cfg_wdata_i,    // timeout_frames

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] time_of_day, [23:17] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] mode, [2] show_24_hour, [7:3] edit_hour,
                                      // [13:8] edit_minute, [20:14] fine_adjust,
                                      // [21] load_time, [38:22] new_time, [39] persist_fine
);

`include "assert_macros.svh"

  typedef struct packed {
    logic        persist_fine;
    logic [16:0] new_time;
    logic        load_time;
    logic [6:0]  fine_adjust;
    logic [5:0]  edit_minute;
    logic [4:0]  edit_hour;
    logic        show_24_hour;
    mode_e       mode;
  } res_t;

  logic [15:0] timeout_q;

  // split stage
  split_t split;
  logic   s1_valid_q;
  cmd_e   s1_cmd_q;
  split_t s1_split_q;

  // state
  mode_e       mode_q, mode_d;
  logic [15:0] cnt_q, cnt_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [6:0]  fine_q, fine_d;
  logic        fmt_q, fmt_d;
  logic        load, persist;
  logic [16:0] new_time;

  // result stage
  logic res_valid_q;
  res_t res_q;

  logic acc_in, adv2;

  assign adv2          = s1_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv2;
  assign acc_in        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'(TimeoutDefault);
    end else if (cfg_wen_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  csmc_tod_split u_split (
    .tod_i   (s_axis_tdata[16:0]),
    .split_o (split)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc_in) begin
      s1_valid_q <= 1'b1;
    end else if (adv2) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      s1_cmd_q   <= cmd_e'(s_axis_tuser);
      s1_split_q <= split;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    hour_d   = hour_q;
    min_d    = min_q;
    fine_d   = fine_q;
    fmt_d    = fmt_q;
    load     = 1'b0;
    persist  = 1'b0;
    new_time = '0;
    unique case (s1_cmd_q)
      CmdTick: begin
        // countdown frozen in time display; zero wraps to all ones
        if (mode_q != ModeTime) begin
          cnt_d = cnt_q - 16'd1;
          if (cnt_d == '0) begin
            mode_d = ModeTime;
          end
        end
      end
      CmdNext: begin
        cnt_d   = timeout_q;
        persist = (mode_q == ModeFine);
        mode_d  = mode_e'(2'(mode_q + 2'd1));
        if (mode_d == ModeHour) begin
          hour_d = s1_split_q.hour;
          min_d  = s1_split_q.minute;
        end else if (mode_d == ModeTime) begin
          load     = 1'b1;
          new_time = 17'(hour_q) * 17'(SecsPerHour) + 17'(min_q) * 17'(SecsPerMin);
        end
      end
      CmdInc: begin
        cnt_d = timeout_q;
        case (mode_q)
          ModeHour:   hour_d = (hour_q == 5'(HoursPerDay - 1)) ? '0 : hour_q + 5'd1;
          ModeMinute: min_d  = (min_q == 6'(MinsPerHour - 1)) ? '0 : min_q + 6'd1;
          ModeFine:   fine_d = (fine_q < 7'(FineMax)) ? fine_q + 7'd1 : '0;
          default:    fmt_d  = ~fmt_q;
        endcase
      end
      CmdNone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeTime;
      cnt_q  <= '0;
      hour_q <= '0;
      min_q  <= '0;
      fine_q <= '0;
      fmt_q  <= 1'b0;
    end else if (adv2) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      hour_q <= hour_d;
      min_q  <= min_d;
      fine_q <= fine_d;
      fmt_q  <= fmt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv2) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      res_q.mode         <= mode_d;
      res_q.show_24_hour <= fmt_d;
      res_q.edit_hour    <= hour_d;
      res_q.edit_minute  <= min_d;
      res_q.fine_adjust  <= fine_d;
      res_q.load_time    <= load;
      res_q.new_time     <= new_time;
      res_q.persist_fine <= persist;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q;

  `ASSERT_ALWAYS(a_edit_range, (hour_q < 5'(HoursPerDay)) && (min_q < 6'(MinsPerHour)) && (fine_q <= 7'(FineMax)), "edit value out of range")
  `ASSERT_IMPL(a_persist_load, res_valid_q && res_q.persist_fine, res_q.load_time, "persist without load")
  `ASSERT_IMPL(a_load_mode, res_valid_q && res_q.load_time, res_q.mode == ModeTime, "load outside time display")
  `ASSERT_IMPL(a_newt_zero, res_valid_q && !res_q.load_time, res_q.new_time == '0, "new_time set without load")
  `ASSERT_NEXT(a_cnt_reload, adv2 && (s1_cmd_q == CmdNext || s1_cmd_q == CmdInc), cnt_q == $past(timeout_q), "countdown not reloaded on button")

endmodule

### sv/csmc_tod_split.sv
// ----------------------------------------------------------------------------
// csmc_tod_split
// Splits seconds since midnight into hour and minute.
// ----------------------------------------------------------------------------
module csmc_tod_split
  import csmc_pkg::*;
(
  input  logic [16:0] tod_i,
  output split_t      split_o
);

  logic [16:0] tod;
  logic [4:0]  hour;
  logic [16:0] base;
  logic [11:0] rem;
  logic [19:0] prod;

  always_comb begin
    tod = (tod_i >= 17'(SecsPerDay)) ? tod_i - 17'(SecsPerDay) : tod_i;
    // independent threshold compares, last hit wins
    hour = '0;
    base = '0;
    for (int k = 1; k < HoursPerDay; k++) begin
      if (tod >= 17'(k * SecsPerHour)) begin
        hour = 5'(k);
        base = 17'(k * SecsPerHour);
      end
    end
    rem  = 12'(tod - base);
    prod = 20'(rem[11:2]) * 20'(MinRecip);
  end

  assign split_o.hour   = hour;
  assign split_o.minute = 6'(prod >> MinShift);

endmodule
